@@ sv/ptwq_pkg.sv @@
package ptwq_pkg;

   // Physical address width of the walker; table bases are limited to it.
   localparam int PHYS_ADDR_BITS_DEFAULT = 52;

   // Depth of the queue between the classifying front and the result back end.
   localparam int QUEUE_DEPTH = 2;

   // Command codes on the request channel.
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // Masks taken from the x86-64 entry layout.
   localparam logic [51:0] TABLE_MASK = 52'hFFFFFFFFFF000;
   localparam logic [51:0] HUGE_MASK  = 52'hFFFFFFFE00000;
   localparam logic [63:0] PAGE_OFF   = 64'h0000000000000FFF;
   localparam logic [63:0] HUGE_OFF   = 64'h00000000001FFFFF;
   localparam logic [63:0] AD_CLEAR   = 64'h0000000000000060;

   // Entry bit positions.
   localparam int BIT_PRESENT  = 0;
   localparam int BIT_WRITABLE = 1;
   localparam int BIT_USER     = 2;
   localparam int BIT_ACCESSED = 5;
   localparam int BIT_DIRTY    = 6;
   localparam int BIT_HUGE     = 7;
   localparam int BIT_NX       = 63;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_WRITE   = 2'd1,
      KIND_TRANS   = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   // Walk state: idle, or waiting for the entry of table level 3..0.
   typedef enum logic [2:0] {
      WALK_IDLE,
      WALK_L3,
      WALK_L2,
      WALK_L1,
      WALK_L0
   } walk_state_type;

   // Work handed from the front to the back end.
   typedef enum logic [1:0] {
      OP_READ,
      OP_FINISH,
      OP_EARLY,
      OP_INVALID
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [51:0] req_addr;
      logic [51:0] phys;
      logic [63:0] entry;
      logic [63:0] vpage;
      logic        huge;
   } action_type;

   // One result transfer.
   typedef struct packed {
      kind_type    kind;
      logic [51:0] address;
      logic [63:0] write_data;
      logic [63:0] virt_page;
      logic        present;
      logic        huge;
      logic        writable;
      logic        user_access;
      logic        accessed;
      logic        dirty;
      logic        executable;
      logic        last;
   } rsp_type;

endpackage

@@ sv/page_table_walk_query.sv @@
// Four-level page table walker with an external memory port. A query transfer
// (req_command 0) with a table root and virtual address starts a walk and produces
// a read request (an invalid result for a zero root, a translation when the masked
// root base is zero); each read-data transfer (req_command 1) returns the requested
// entry and produces the next read request, a translation when the next base is
// zero, or, at the end of the walk, a write-back request followed by the
// translation. A new query drops any walk in progress, and read data that arrives
// while idle produces nothing. The front end takes one request transfer per cycle
// while the queue is not full and hands the work through a two-entry queue to the
// back end, which drives one response transfer per cycle while rsp_ready is high,
// from an output register. Sustained rate is one request per cycle while each
// request yields one result; a completed walk yields two results.
module page_table_walk_query
   import ptwq_pkg::*;
#(
   parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [51:0] req_table_root,
   input  logic [63:0] req_virt_addr,
   input  logic [63:0] req_read_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [51:0] rsp_address,
   output logic [63:0] rsp_write_data,
   output logic [63:0] rsp_virt_page,
   output logic        rsp_present,
   output logic        rsp_huge,
   output logic        rsp_writable,
   output logic        rsp_user_access,
   output logic        rsp_accessed,
   output logic        rsp_dirty,
   output logic        rsp_executable,
   output logic        rsp_last
);

   logic       q_push;
   logic       q_pop;
   logic       q_full;
   logic       q_not_empty;
   action_type q_data;
   action_type q_head;
   rsp_type    rsp_data;

   // Walk state and request classification.
   ptwq_front #(
      .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_table_root (req_table_root),
      .req_virt_addr  (req_virt_addr),
      .req_read_data  (req_read_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_data)
   );

   // Decoupling queue.
   ptwq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // Result sequencing and output register.
   ptwq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_address     = rsp_data.address;
   assign rsp_write_data  = rsp_data.write_data;
   assign rsp_virt_page   = rsp_data.virt_page;
   assign rsp_present     = rsp_data.present;
   assign rsp_huge        = rsp_data.huge;
   assign rsp_writable    = rsp_data.writable;
   assign rsp_user_access = rsp_data.user_access;
   assign rsp_accessed    = rsp_data.accessed;
   assign rsp_dirty       = rsp_data.dirty;
   assign rsp_executable  = rsp_data.executable;
   assign rsp_last        = rsp_data.last;

   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("work pushed into a full queue");

   // Only a write-back result leaves its transfer's results unfinished.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_kind == KIND_WRITE))
      else $error("non-final result that is not a write-back");

   // A write-back transfer is followed at once by its translation.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && rsp_kind == KIND_TRANS))
      else $error("write-back not followed by its translation");

endmodule

@@ sv/ptwq_front.sv @@
module ptwq_front
   import ptwq_pkg::*;
#(
   parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [51:0] req_table_root,
   input  logic [63:0] req_virt_addr,
   input  logic [63:0] req_read_data,
   input  logic        q_full,
   output logic        q_push,
   output action_type  q_data
);

   localparam logic [51:0] ADDR_LIMIT = 52'((53'd1 << PHYS_ADDR_BITS) - 53'd1);

   walk_state_type walk_ff, walk_in;
   logic [63:0]    saved_virt_ff, saved_virt_in;
   logic [51:0]    base_ff, base_in;

   logic           accept;
   logic           query;
   logic           walking;
   logic           root_zero;
   logic [51:0]    root_base;
   logic [51:0]    data_base;
   logic [51:0]    huge_phys;
   logic [51:0]    next_base;
   logic           base_zero;
   logic           take_huge;
   logic           do_finish;
   logic [1:0]     cur_lvl;
   logic [8:0]     cur_idx;
   logic [8:0]     nxt_idx;
   logic [8:0]     root_idx;

   // Nine-bit table index of a virtual address for one level.
   function automatic logic [8:0] level_index(input logic [63:0] va, input logic [1:0] lvl);
      logic [8:0] idx;
      case (lvl)
         2'd0:    idx = va[20:12];
         2'd1:    idx = va[29:21];
         2'd2:    idx = va[38:30];
         default: idx = va[47:39];
      endcase
      return idx;
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign query     = (req_command == CMD_QUERY);
   assign walking   = (walk_ff != WALK_IDLE);

   // Table bases and page frames, limited to the physical address width.
   assign root_zero = (req_table_root == '0);
   assign root_base = req_table_root & TABLE_MASK & ADDR_LIMIT;
   assign data_base = req_read_data[51:0] & TABLE_MASK & ADDR_LIMIT;
   assign huge_phys = req_read_data[51:0] & HUGE_MASK & ADDR_LIMIT;
   assign next_base = query ? root_base : data_base;
   assign base_zero = (next_base == '0);

   // Level of the entry now awaited, and the indexes into that table and the next.
   always_comb begin
      case (walk_ff)
         WALK_L3: cur_lvl = 2'd3;
         WALK_L2: cur_lvl = 2'd2;
         WALK_L1: cur_lvl = 2'd1;
         default: cur_lvl = 2'd0;
      endcase
   end

   assign cur_idx  = level_index(saved_virt_ff, cur_lvl);
   assign nxt_idx  = level_index(saved_virt_ff, cur_lvl - 2'd1);
   assign root_idx = level_index(req_virt_addr, 2'd3);

   // A walk ends at the leaf, or at a directory entry that maps a 2 MiB page.
   assign take_huge = (walk_ff == WALK_L1) && req_read_data[BIT_HUGE];
   assign do_finish = !query && ((walk_ff == WALK_L0) || take_huge);

   // Next state of the walk.
   always_comb begin
      walk_in       = walk_ff;
      saved_virt_in = saved_virt_ff;
      base_in       = base_ff;
      if (accept) begin
         if (query) begin
            if (root_zero) begin
               walk_in = WALK_IDLE;
            end else begin
               saved_virt_in = req_virt_addr;
               if (base_zero) begin
                  walk_in = WALK_IDLE;
               end else begin
                  walk_in = WALK_L3;
                  base_in = root_base;
               end
            end
         end else if (walking) begin
            if (do_finish || base_zero) begin
               walk_in = WALK_IDLE;
            end else begin
               base_in = data_base;
               case (walk_ff)
                  WALK_L3: walk_in = WALK_L2;
                  WALK_L2: walk_in = WALK_L1;
                  WALK_L1: walk_in = WALK_L0;
                  default: walk_in = WALK_IDLE;
               endcase
            end
         end
      end
   end

   // Work handed to the back end for each transfer that causes results.
   always_comb begin
      q_push = 1'b0;
      q_data = '0;
      if (accept) begin
         if (query) begin
            q_push = 1'b1;
            if (root_zero) begin
               q_data.op = OP_INVALID;
            end else if (base_zero) begin
               q_data.op    = OP_EARLY;
               q_data.vpage = req_virt_addr & ~PAGE_OFF;
            end else begin
               q_data.op       = OP_READ;
               q_data.req_addr = {root_base[51:12], root_idx, 3'b000};
            end
         end else if (walking) begin
            q_push = 1'b1;
            if (do_finish) begin
               q_data.op       = OP_FINISH;
               q_data.req_addr = {base_ff[51:12], cur_idx, 3'b000};
               q_data.entry    = req_read_data;
               q_data.huge     = take_huge;
               q_data.phys     = take_huge ? huge_phys : data_base;
               q_data.vpage    = take_huge ? (saved_virt_ff & ~HUGE_OFF)
                                           : (saved_virt_ff & ~PAGE_OFF);
            end else if (base_zero) begin
               q_data.op    = OP_EARLY;
               q_data.vpage = saved_virt_ff & ~PAGE_OFF;
            end else begin
               q_data.op       = OP_READ;
               q_data.req_addr = {data_base[51:12], nxt_idx, 3'b000};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff       <= WALK_IDLE;
         saved_virt_ff <= '0;
         base_ff       <= '0;
      end else begin
         walk_ff       <= walk_in;
         saved_virt_ff <= saved_virt_in;
         base_ff       <= base_in;
      end
   end

endmodule

@@ sv/ptwq_queue.sv @@
module ptwq_queue
   import ptwq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  action_type push_data,
   input  logic       pop,
   output logic       full,
   output logic       not_empty,
   output action_type head
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);

   action_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/ptwq_back.sv @@
module ptwq_back
   import ptwq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  action_type q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       beat_ff, beat_in;
   logic       load;
   logic       beat_last;
   rsp_type    beat;

   // The output register takes a new result when empty or being transferred.
   assign load = !rsp_valid_ff || rsp_ready;

   // A finished walk gives a write-back and then a translation; others give one result.
   assign beat_last = (q_head.op != OP_FINISH) || beat_ff;
   assign q_pop     = load && q_not_empty && beat_last;

   // Build the result for the current beat of the head entry.
   always_comb begin
      beat = '0;
      case (q_head.op)
         OP_READ: begin
            beat.kind    = KIND_READ;
            beat.address = q_head.req_addr;
            beat.last    = 1'b1;
         end
         OP_EARLY: begin
            beat.kind       = KIND_TRANS;
            beat.virt_page  = q_head.vpage;
            beat.executable = 1'b1;
            beat.last       = 1'b1;
         end
         OP_FINISH: begin
            if (!beat_ff) begin
               beat.kind       = KIND_WRITE;
               beat.address    = q_head.req_addr;
               beat.write_data = q_head.entry & ~AD_CLEAR;
            end else begin
               beat.kind        = KIND_TRANS;
               beat.address     = q_head.phys;
               beat.virt_page   = q_head.vpage;
               beat.present     = q_head.entry[BIT_PRESENT];
               beat.huge        = q_head.huge;
               beat.writable    = q_head.entry[BIT_WRITABLE];
               beat.user_access = q_head.entry[BIT_USER];
               beat.accessed    = q_head.entry[BIT_ACCESSED];
               beat.dirty       = q_head.entry[BIT_DIRTY];
               beat.executable  = !q_head.entry[BIT_NX];
               beat.last        = 1'b1;
            end
         end
         default: begin
            beat.kind = KIND_INVALID;
            beat.last = 1'b1;
         end
      endcase
   end

   // Output register and beat tracking.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      beat_in      = beat_ff;
      if (load) begin
         rsp_valid_in = q_not_empty;
         if (q_not_empty) begin
            rsp_data_in = beat;
            beat_in     = !beat_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
